// ----- rtl/smx_pkg.sv -----
// Shared types and constants for the stack machine execute unit.
package smx_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int STACK_DEPTH = 256;
  localparam int NUM_REGS    = 6;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
  localparam int OP_W        = 4;
  localparam int REG_IDX_W   = 3;
  localparam int STATUS_W    = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 4'd0,
    OP_POP     = 4'd1,
    OP_ADD     = 4'd2,
    OP_HALT    = 4'd3,
    OP_MUL     = 4'd4,
    OP_NEG     = 4'd5,
    OP_SQR     = 4'd6,
    OP_POW     = 4'd7,
    OP_SHOW    = 4'd8,
    OP_DIF     = 4'd9,
    OP_SUB     = 4'd10,
    OP_SET     = 4'd11,
    OP_READREG = 4'd12,
    OP_PUSHREG = 4'd13,
    OP_MOVE    = 4'd14,
    OP_STR     = 4'd15
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_UNDER  = 3'd1,
    ST_OVER   = 3'd2,
    ST_HALTED = 3'd3,
    ST_BADREG = 3'd4
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture item, start stack read
    logic mul_op;    // single multiply for mul or sqr
    logic pow_init;  // set up square-and-multiply
    logic pow_mul;   // accumulate when exponent bit is set
    logic pow_sqr;   // square base, shift exponent
    logic commit;    // update state and load result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic use_mul;   // item is a valid mul, sqr or pow
    logic is_pow;
    logic exp_last;  // no exponent bits left after this shift
  } sts_t;

endpackage

// ----- rtl/smx_ctrl.sv -----
// Sequencing state machine and result-valid tracking for the stack machine.
module smx_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  smx_pkg::sts_t sts,
  output smx_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EVAL   = 6'b000010,
    S_MUL    = 6'b000100,
    S_PMUL   = 6'b001000,
    S_PSQR   = 6'b010000,
    S_COMMIT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // result register can take a new item when empty or being drained
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.use_mul) begin
          if (sts.is_pow) begin
            cmd.pow_init = 1'b1;
            state_nxt    = S_PMUL;
          end else begin
            state_nxt = S_MUL;
          end
        end else if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_MUL: begin
        cmd.mul_op = 1'b1;
        state_nxt  = S_COMMIT;
      end
      S_PMUL: begin
        cmd.pow_mul = 1'b1;
        state_nxt   = S_PSQR;
      end
      S_PSQR: begin
        cmd.pow_sqr = 1'b1;
        state_nxt   = sts.exp_last ? S_COMMIT : S_PMUL;
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // a pending result is never overwritten
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> out_free)
    else $error("commit while result register is held");

  // every commit presents a result
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed item not presented");

  // power loop ends once the exponent runs out
  a_pow_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PSQR) && sts.exp_last |=> (state_r == S_COMMIT))
    else $error("power loop did not finish");
`endif

endmodule

// ----- rtl/smx_dp.sv -----
// Datapath: operand stack, register file, shared multiplier and result register.
module smx_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  smx_pkg::cmd_t                       cmd,
  output smx_pkg::sts_t                       sts,
  input  logic [smx_pkg::OP_W-1:0]            in_operation,
  input  logic [smx_pkg::REG_IDX_W-1:0]       in_first_reg,
  input  logic [smx_pkg::REG_IDX_W-1:0]       in_second_reg,
  input  logic signed [smx_pkg::DATA_WIDTH-1:0] in_immediate,
  output logic [smx_pkg::STATUS_W-1:0]        out_status,
  output logic [smx_pkg::FILL_W-1:0]          out_stack_count,
  output logic signed [smx_pkg::DATA_WIDTH-1:0] out_top_value,
  output logic signed [smx_pkg::DATA_WIDTH-1:0] out_reg_value,
  output logic                                out_halted
);

  localparam int DW = smx_pkg::DATA_WIDTH;
  localparam int FW = smx_pkg::FILL_W;
  localparam int AW = smx_pkg::ADDR_W;
  localparam int RW = smx_pkg::REG_IDX_W;

  // captured item
  smx_pkg::op_t  op_r;
  logic [RW-1:0] r1_r, r2_r;
  logic [DW-1:0] imm_r;

  // architectural state: top of stack lives in top_r, the rest in stack_mem
  logic [DW-1:0] stack_mem [smx_pkg::STACK_DEPTH];
  logic [DW-1:0] rd_r;
  logic [DW-1:0] top_r, top_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          halt_r, halt_nxt;
  logic [DW-1:0] regs_r [smx_pkg::NUM_REGS];

  // multiplier working registers
  logic [DW-1:0] acc_r, base_r, exp_r;
  logic [DW-1:0] mul_x, mul_y, prod;

  // result register
  logic [smx_pkg::STATUS_W-1:0] st_out_r;
  logic [FW-1:0]                cnt_out_r;
  logic [DW-1:0]                top_out_r, rv_out_r;
  logic                         halt_out_r;

  smx_pkg::status_t st;
  logic          r1ok, r2ok, empty, lt2, full, ok;
  logic [FW-1:0] fill_m1, fill_m2;
  logic [DW-1:0] reg_rd, diff, rv, alu_res;
  logic          mem_we;
  logic          reg_we;
  logic [RW-1:0] reg_wa;
  logic [DW-1:0] reg_wd;

  assign r1ok    = r1_r < RW'(smx_pkg::NUM_REGS);
  assign r2ok    = r2_r < RW'(smx_pkg::NUM_REGS);
  assign empty   = (fill_r == '0);
  assign lt2     = (fill_r < FW'(2));
  assign full    = (fill_r == FW'(smx_pkg::STACK_DEPTH));
  assign fill_m1 = fill_r - FW'(1);
  assign fill_m2 = fill_r - FW'(2);
  assign reg_rd  = regs_r[r1_r];
  assign diff    = rd_r - top_r;

  // status of the captured item
  always_comb begin
    st = smx_pkg::ST_OK;
    if (halt_r) begin
      st = smx_pkg::ST_HALTED;
    end else begin
      unique case (op_r)
        smx_pkg::OP_PUSH:    if (full) st = smx_pkg::ST_OVER;
        smx_pkg::OP_PUSHREG: begin
          if (!r1ok)     st = smx_pkg::ST_BADREG;
          else if (full) st = smx_pkg::ST_OVER;
        end
        smx_pkg::OP_POP, smx_pkg::OP_NEG, smx_pkg::OP_SQR:
          if (empty) st = smx_pkg::ST_UNDER;
        smx_pkg::OP_ADD, smx_pkg::OP_MUL, smx_pkg::OP_POW, smx_pkg::OP_DIF,
        smx_pkg::OP_SUB:
          if (lt2) st = smx_pkg::ST_UNDER;
        smx_pkg::OP_HALT, smx_pkg::OP_SHOW: st = smx_pkg::ST_OK;
        smx_pkg::OP_SET, smx_pkg::OP_READREG:
          if (!r1ok) st = smx_pkg::ST_BADREG;
        smx_pkg::OP_MOVE:
          if (!r1ok || !r2ok) st = smx_pkg::ST_BADREG;
        smx_pkg::OP_STR: begin
          if (!r1ok)      st = smx_pkg::ST_BADREG;
          else if (empty) st = smx_pkg::ST_UNDER;
        end
      endcase
    end
  end

  assign ok           = (st == smx_pkg::ST_OK);
  assign sts.use_mul  = ok && (op_r == smx_pkg::OP_MUL || op_r == smx_pkg::OP_SQR ||
                               op_r == smx_pkg::OP_POW);
  assign sts.is_pow   = (op_r == smx_pkg::OP_POW);
  assign sts.exp_last = (exp_r[DW-1:1] == '0);

  // shared multiplier, low word only
  always_comb begin
    mul_x = acc_r;
    mul_y = base_r;
    if (cmd.mul_op) begin
      mul_x = (op_r == smx_pkg::OP_SQR) ? top_r : rd_r;
      mul_y = top_r;
    end else if (cmd.pow_sqr) begin
      mul_x = base_r;
    end
  end
  assign prod = mul_x * mul_y;

  // multiply and power registers
  always_ff @(posedge clk) begin
    if (cmd.mul_op) begin
      acc_r <= prod;
    end else if (cmd.pow_init) begin
      acc_r  <= DW'(1);
      base_r <= rd_r;
      // exponent below one counts as one
      exp_r  <= (top_r == '0 || top_r[DW-1]) ? DW'(1) : top_r;
    end else if (cmd.pow_mul) begin
      if (exp_r[0]) acc_r <= prod;
    end else if (cmd.pow_sqr) begin
      base_r <= prod;
      exp_r  <= exp_r >> 1;
    end
  end

  // combinational results of add, sub, dif and neg; acc_r for mul, sqr and pow
  always_comb begin
    unique case (op_r)
      smx_pkg::OP_ADD: alu_res = rd_r + top_r;
      smx_pkg::OP_SUB: alu_res = diff;
      smx_pkg::OP_DIF: alu_res = diff[DW-1] ? ('0 - diff) : diff;
      smx_pkg::OP_NEG: alu_res = '0 - top_r;
      default:         alu_res = acc_r;
    endcase
  end

  // next architectural state for a committed item
  always_comb begin
    top_nxt  = top_r;
    fill_nxt = fill_r;
    halt_nxt = halt_r;
    mem_we   = 1'b0;
    reg_we   = 1'b0;
    reg_wa   = r1_r;
    reg_wd   = imm_r;
    rv       = '0;
    if (ok) begin
      unique case (op_r)
        smx_pkg::OP_PUSH, smx_pkg::OP_PUSHREG: begin
          mem_we   = !empty;
          top_nxt  = (op_r == smx_pkg::OP_PUSH) ? imm_r : reg_rd;
          fill_nxt = fill_r + FW'(1);
          if (op_r == smx_pkg::OP_PUSHREG) rv = reg_rd;
        end
        smx_pkg::OP_POP: begin
          top_nxt  = rd_r;
          fill_nxt = fill_m1;
        end
        smx_pkg::OP_NEG, smx_pkg::OP_SQR: top_nxt = alu_res;
        smx_pkg::OP_ADD, smx_pkg::OP_MUL, smx_pkg::OP_POW, smx_pkg::OP_DIF,
        smx_pkg::OP_SUB: begin
          top_nxt  = alu_res;
          fill_nxt = fill_m1;
        end
        smx_pkg::OP_HALT: halt_nxt = 1'b1;
        smx_pkg::OP_SHOW: ;
        smx_pkg::OP_SET:  reg_we = 1'b1;
        smx_pkg::OP_READREG: rv = reg_rd;
        smx_pkg::OP_MOVE: begin
          reg_we = 1'b1;
          reg_wa = r2_r;
          reg_wd = reg_rd;
        end
        smx_pkg::OP_STR: begin
          reg_we = 1'b1;
          reg_wd = top_r;
        end
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r  <= smx_pkg::OP_SHOW;
      r1_r  <= '0;
      r2_r  <= '0;
      imm_r <= '0;
    end else if (cmd.load) begin
      op_r  <= smx_pkg::op_t'(in_operation);
      r1_r  <= in_first_reg;
      r2_r  <= in_second_reg;
      imm_r <= in_immediate;
    end
  end

  // stack memory: entry below the top is read when the item is taken
  always_ff @(posedge clk) begin
    if (cmd.commit && mem_we) begin
      stack_mem[fill_m1[AW-1:0]] <= top_r;
    end
    if (cmd.load) begin
      rd_r <= stack_mem[fill_m2[AW-1:0]];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      halt_r <= 1'b0;
      for (int i = 0; i < smx_pkg::NUM_REGS; i++) begin
        regs_r[i] <= '0;
      end
    end else if (cmd.commit) begin
      fill_r <= fill_nxt;
      halt_r <= halt_nxt;
      if (reg_we) regs_r[reg_wa] <= reg_wd;
    end
  end

  // top of stack and result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      top_r      <= top_nxt;
      st_out_r   <= st;
      cnt_out_r  <= fill_nxt;
      top_out_r  <= (fill_nxt != '0) ? top_nxt : '0;
      rv_out_r   <= rv;
      halt_out_r <= halt_nxt;
    end
  end

  assign out_status      = st_out_r;
  assign out_stack_count = cnt_out_r;
  assign out_top_value   = top_out_r;
  assign out_reg_value   = rv_out_r;
  assign out_halted      = halt_out_r;

`ifndef NO_ASSERTIONS
  // fill never passes the stack depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(smx_pkg::STACK_DEPTH))
    else $error("stack fill out of range");

  // a refused item leaves fill and halt alone
  a_refused: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && !ok |=> $stable(fill_r) && $stable(halt_r))
    else $error("refused item changed state");

  // halt is sticky
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag cleared");
`endif

endmodule

// ----- rtl/stack_machine_execute_unit.sv -----
// Stack machine execute unit: top level joining controller and datapath.
// Executes one decoded instruction per item against a 256-entry operand stack
// (top entry in a register, the rest in a single-port memory), six general
// registers and a halt flag, returning one result item per input item. Items are
// taken one at a time: push, pop, add, sub, dif, neg, set, move and the register
// ops capture the item with a registered stack read, then execute; mul and sqr
// add one multiply step, and pow a multiply and a square step per significant
// exponent bit (at most 31) of square-and-multiply on the one shared 32x32
// multiplier. A new item is taken while the previous result still waits in the
// output register. No clearing follows reset; reads above the fill go unused.
module stack_machine_execute_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [smx_pkg::OP_W-1:0]              in_operation,
  input  logic [smx_pkg::REG_IDX_W-1:0]         in_first_reg,
  input  logic [smx_pkg::REG_IDX_W-1:0]         in_second_reg,
  input  logic signed [smx_pkg::DATA_WIDTH-1:0] in_immediate,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [smx_pkg::STATUS_W-1:0]          out_status,
  output logic [smx_pkg::FILL_W-1:0]            out_stack_count,
  output logic signed [smx_pkg::DATA_WIDTH-1:0] out_top_value,
  output logic signed [smx_pkg::DATA_WIDTH-1:0] out_reg_value,
  output logic                                  out_halted
);

  smx_pkg::cmd_t cmd;
  smx_pkg::sts_t sts;

  smx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  smx_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_operation),
    .in_first_reg    (in_first_reg),
    .in_second_reg   (in_second_reg),
    .in_immediate    (in_immediate),
    .out_status      (out_status),
    .out_stack_count (out_stack_count),
    .out_top_value   (out_top_value),
    .out_reg_value   (out_reg_value),
    .out_halted      (out_halted)
  );

endmodule

// ----- sim/stack_machine_execute_unit_tb.sv -----
// Self-checking testbench for the stack machine execute unit, with a built-in instruction predictor.
module stack_machine_execute_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import smx_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RANDOM_ITEMS   = 1420;
  localparam int PHASE_LEN      = 470;
  localparam int LONG_HOLD      = 150;
  localparam int DRAIN_CYCLES   = 80;
  localparam int HALT_TAIL      = 8;
  localparam int TIMEOUT_CYCLES = 1_000_000;

  typedef struct packed {
    op_t                   op;
    logic [REG_IDX_W-1:0]  r1;
    logic [REG_IDX_W-1:0]  r2;
    logic [DATA_WIDTH-1:0] imm;
  } instr_t;

  typedef struct packed {
    status_t               status;
    logic [FILL_W-1:0]     count;
    logic [DATA_WIDTH-1:0] top;
    logic [DATA_WIDTH-1:0] rdata;
    logic                  halted;
  } outcome_t;

  typedef struct packed {
    instr_t   instr;
    logic     fixed;
    outcome_t want;
  } script_row_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [OP_W-1:0]              in_operation = '0;
  logic [REG_IDX_W-1:0]         in_first_reg = '0;
  logic [REG_IDX_W-1:0]         in_second_reg = '0;
  logic signed [DATA_WIDTH-1:0] in_immediate = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [STATUS_W-1:0]          out_status;
  logic [FILL_W-1:0]            out_stack_count;
  logic signed [DATA_WIDTH-1:0] out_top_value;
  logic signed [DATA_WIDTH-1:0] out_reg_value;
  logic                         out_halted;

  // Predicted machine state
  logic [DATA_WIDTH-1:0] vm_stack [STACK_DEPTH];
  logic [DATA_WIDTH-1:0] vm_regs  [NUM_REGS];
  int                    vm_fill;
  logic                  vm_halted;

  outcome_t    pending_outcomes[$];
  script_row_t directed_rows[$];
  int          errors;
  int          sender_idle_pct;
  int          receiver_idle_pct;
  int          hold_left;
  logic        long_hold_req;
  logic        long_hold_done;

  stack_machine_execute_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_first_reg   (in_first_reg),
    .in_second_reg  (in_second_reg),
    .in_immediate   (in_immediate),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_stack_count(out_stack_count),
    .out_top_value  (out_top_value),
    .out_reg_value  (out_reg_value),
    .out_halted     (out_halted)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Square-and-multiply, exponent below one taken as one
  function automatic logic [DATA_WIDTH-1:0] raise_power(logic [DATA_WIDTH-1:0] base,
                                                        logic [DATA_WIDTH-1:0] expo);
    logic [DATA_WIDTH-1:0] acc;
    acc = 1;
    if (expo == 0 || expo[DATA_WIDTH-1]) expo = 1;
    while (expo != 0) begin
      if (expo[0]) acc = acc * base;
      base = base * base;
      expo = expo >> 1;
    end
    return acc;
  endfunction

  // Execute one instruction on the predicted state and return its outcome
  function automatic outcome_t execute_instr(instr_t it);
    outcome_t              res;
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
    logic [DATA_WIDTH-1:0] r;
    logic                  r1ok;
    logic                  r2ok;
    res.status = ST_OK;
    res.rdata  = '0;
    r1ok = it.r1 < NUM_REGS;
    r2ok = it.r2 < NUM_REGS;
    if (vm_halted) begin
      res.status = ST_HALTED;
    end else begin
      case (it.op)
        OP_PUSH, OP_PUSHREG: begin
          // register number is checked ahead of the stack
          if (it.op == OP_PUSHREG && !r1ok) res.status = ST_BADREG;
          else if (vm_fill >= STACK_DEPTH) res.status = ST_OVER;
          else begin
            r = (it.op == OP_PUSH) ? it.imm : vm_regs[it.r1];
            if (it.op == OP_PUSHREG) res.rdata = r;
            vm_stack[vm_fill] = r;
            vm_fill++;
          end
        end
        OP_POP: begin
          if (vm_fill < 1) res.status = ST_UNDER;
          else vm_fill--;
        end
        OP_NEG, OP_SQR: begin
          if (vm_fill < 1) res.status = ST_UNDER;
          else begin
            a = vm_stack[vm_fill-1];
            vm_stack[vm_fill-1] = (it.op == OP_NEG) ? (0 - a) : (a * a);
          end
        end
        OP_ADD, OP_MUL, OP_POW, OP_DIF, OP_SUB: begin
          if (vm_fill < 2) res.status = ST_UNDER;
          else begin
            a = vm_stack[vm_fill-1];
            b = vm_stack[vm_fill-2];
            case (it.op)
              OP_ADD: r = b + a;
              OP_MUL: r = b * a;
              OP_POW: r = raise_power(b, a);
              default: begin
                r = b - a;
                if (it.op == OP_DIF && r[DATA_WIDTH-1]) r = 0 - r;
              end
            endcase
            vm_fill--;
            vm_stack[vm_fill-1] = r;
          end
        end
        OP_HALT: vm_halted = 1'b1;
        OP_SET: begin
          if (!r1ok) res.status = ST_BADREG;
          else vm_regs[it.r1] = it.imm;
        end
        OP_READREG: begin
          if (!r1ok) res.status = ST_BADREG;
          else res.rdata = vm_regs[it.r1];
        end
        OP_MOVE: begin
          if (!r1ok || !r2ok) res.status = ST_BADREG;
          else vm_regs[it.r2] = vm_regs[it.r1];
        end
        OP_STR: begin
          if (!r1ok) res.status = ST_BADREG;
          else if (vm_fill < 1) res.status = ST_UNDER;
          else vm_regs[it.r1] = vm_stack[vm_fill-1];
        end
        default: ; // show leaves everything alone
      endcase
    end
    res.count  = FILL_W'(vm_fill);
    res.top    = (vm_fill > 0) ? vm_stack[vm_fill-1] : '0;
    res.halted = vm_halted;
    return res;
  endfunction

  // Directed row whose outcome comes from the predictor
  function automatic script_row_t open_row(op_t op, int r1, int r2, logic [DATA_WIDTH-1:0] imm);
    script_row_t row;
    row.instr.op  = op;
    row.instr.r1  = REG_IDX_W'(r1);
    row.instr.r2  = REG_IDX_W'(r2);
    row.instr.imm = imm;
    row.fixed     = 1'b0;
    row.want      = '0;
    return row;
  endfunction

  // Directed row with its outcome written out (never halted in the table)
  function automatic script_row_t fixed_row(op_t op, int r1, int r2, logic [DATA_WIDTH-1:0] imm,
                                            status_t st, int cnt, logic [DATA_WIDTH-1:0] top,
                                            logic [DATA_WIDTH-1:0] rdata);
    script_row_t row;
    row              = open_row(op, r1, r2, imm);
    row.fixed        = 1'b1;
    row.want.status  = st;
    row.want.count   = FILL_W'(cnt);
    row.want.top     = top;
    row.want.rdata   = rdata;
    row.want.halted  = 1'b0;
    return row;
  endfunction

  // Mostly valid register numbers, with 6 and 7 now and then
  function automatic logic [REG_IDX_W-1:0] pick_reg();
    if ($urandom_range(7) == 0) return REG_IDX_W'($urandom_range(7, NUM_REGS));
    return REG_IDX_W'($urandom_range(NUM_REGS - 1));
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_imm();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5) return $urandom;
    if (sel < 8) return ($urandom_range(1) ? 32'd0 - $urandom_range(15) : $urandom_range(15));
    case ($urandom_range(3))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // Random instruction, biased to fill or to drain the stack
  function automatic instr_t random_instr(logic growing);
    instr_t it;
    int     pick;
    pick = $urandom_range(99);
    if (growing && pick < 65) it.op = OP_PUSH;
    else if (growing && pick < 80) it.op = OP_PUSHREG;
    else if (!growing && pick < 30) it.op = OP_POP;
    else if (!growing && pick < 70) begin
      case ($urandom_range(4))
        0:       it.op = OP_ADD;
        1:       it.op = OP_MUL;
        2:       it.op = OP_POW;
        3:       it.op = OP_DIF;
        default: it.op = OP_SUB;
      endcase
    end else begin
      do it.op = op_t'($urandom_range(15)); while (it.op == OP_HALT);
    end
    it.r1  = pick_reg();
    it.r2  = pick_reg();
    it.imm = pick_imm();
    return it;
  endfunction

  // Offer one item, wait for it to be taken, then queue its outcome
  task automatic offer_instr(input instr_t it, input logic fixed, input outcome_t want);
    outcome_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= it.op;
    in_first_reg  <= it.r1;
    in_second_reg <= it.r2;
    in_immediate  <= it.imm;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = execute_instr(it);
    pending_outcomes.push_back(fixed ? want : predicted);
  endtask

  task automatic check_outcome(input outcome_t got);
    outcome_t want;
    if (pending_outcomes.size() == 0) begin
      $error("unexpected result item: status %0d count %0d", got.status, got.count);
      errors++;
    end else begin
      want = pending_outcomes.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("stack_count: expected %0d, got %0d", want.count, got.count);
        errors++;
      end
      if (got.top !== want.top) begin
        $error("top_value: expected %0d, got %0d", $signed(want.top), $signed(got.top));
        errors++;
      end
      if (got.rdata !== want.rdata) begin
        $error("reg_value: expected %0d, got %0d", $signed(want.rdata), $signed(got.rdata));
        errors++;
      end
      if (got.halted !== want.halted) begin
        $error("halted: expected %0d, got %0d", want.halted, got.halted);
        errors++;
      end
    end
  endtask

  // Result side: check taken items, then drive stall for the next edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      check_outcome('{status: status_t'(out_status), count: out_stack_count,
                      top: out_top_value, rdata: out_reg_value, halted: out_halted});
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (long_hold_req && !long_hold_done) begin
      // long hold-off so the unit backs up and stalls its input
      out_stall      <= 1'b1;
      hold_left      = LONG_HOLD - 1;
      long_hold_done = 1'b1;
    end else begin
      out_stall <= rst_n && ($urandom_range(99) < receiver_idle_pct);
    end
  end

  // Stimulus
  initial begin
    logic   growing;
    instr_t halt_it;
    errors            = 0;
    hold_left         = 0;
    long_hold_req     = 1'b0;
    long_hold_done    = 1'b0;
    sender_idle_pct   = 37;
    receiver_idle_pct = 58;
    vm_fill           = 0;
    vm_halted         = 1'b0;
    growing           = 1'b1;
    foreach (vm_stack[i]) vm_stack[i] = '0;
    foreach (vm_regs[i]) vm_regs[i] = '0;

    // empty stack, registers at zero: errors and reset values
    directed_rows.push_back(fixed_row(OP_POP,     0, 0, 0,   ST_UNDER,  0, 0, 0));
    directed_rows.push_back(fixed_row(OP_ADD,     0, 0, 0,   ST_UNDER,  0, 0, 0));
    directed_rows.push_back(fixed_row(OP_STR,     0, 0, 0,   ST_UNDER,  0, 0, 0));
    // register check wins over the stack check
    directed_rows.push_back(fixed_row(OP_STR,     6, 0, 0,   ST_BADREG, 0, 0, 0));
    directed_rows.push_back(fixed_row(OP_READREG, 5, 0, 0,   ST_OK,     0, 0, 0));
    directed_rows.push_back(fixed_row(OP_SET,     7, 0, 32'h1234, ST_BADREG, 0, 0, 0));
    directed_rows.push_back(fixed_row(OP_MOVE,    0, 6, 0,   ST_BADREG, 0, 0, 0));
    directed_rows.push_back(fixed_row(OP_PUSHREG, 6, 0, 0,   ST_BADREG, 0, 0, 0));
    directed_rows.push_back(fixed_row(OP_SHOW,    0, 0, 0,   ST_OK,     0, 0, 0));
    directed_rows.push_back(fixed_row(OP_PUSH,    0, 0, 32'h7fff_ffff, ST_OK, 1,
                                      32'h7fff_ffff, 0));
    directed_rows.push_back(fixed_row(OP_PUSH,    0, 0, 32'h8000_0000, ST_OK, 2,
                                      32'h8000_0000, 0));
    // wrapping arithmetic on the extremes
    directed_rows.push_back(open_row(OP_ADD,     0, 0, 0));
    directed_rows.push_back(open_row(OP_NEG,     0, 0, 0));
    directed_rows.push_back(open_row(OP_SQR,     0, 0, 0));
    directed_rows.push_back(open_row(OP_SET,     5, 0, 32'h8000_0000));
    directed_rows.push_back(open_row(OP_MOVE,    5, 0, 0));
    directed_rows.push_back(open_row(OP_PUSHREG, 0, 0, 0));
    directed_rows.push_back(open_row(OP_MUL,     0, 0, 0));
    // power with zero and negative exponents
    directed_rows.push_back(open_row(OP_PUSH,    0, 0, 0));
    directed_rows.push_back(open_row(OP_POW,     0, 0, 0));
    directed_rows.push_back(open_row(OP_PUSH,    0, 0, 32'hffff_fffb));
    directed_rows.push_back(open_row(OP_POW,     0, 0, 0));
    // difference whose magnitude wraps
    directed_rows.push_back(open_row(OP_PUSH,    0, 0, 0));
    directed_rows.push_back(open_row(OP_DIF,     0, 0, 0));
    directed_rows.push_back(open_row(OP_PUSHREG, 0, 0, 0));
    directed_rows.push_back(open_row(OP_SUB,     0, 0, 0));
    directed_rows.push_back(open_row(OP_STR,     2, 0, 0));
    directed_rows.push_back(open_row(OP_POP,     0, 0, 0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      offer_instr(directed_rows[i].instr, directed_rows[i].fixed, directed_rows[i].want);

    // random part: sawtooth between an empty and a full stack
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == PHASE_LEN) begin
        sender_idle_pct   = 58;
        receiver_idle_pct = 37;
      end else if (n == 2 * PHASE_LEN) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        long_hold_req     = 1'b1;
      end
      if (vm_fill == STACK_DEPTH && $urandom_range(3) == 0) growing = 1'b0;
      else if (vm_fill == 0 && $urandom_range(2) == 0) growing = 1'b1;
      offer_instr(random_instr(growing), 1'b0, '0);
    end

    // halt, then items that must all be ignored
    halt_it    = '0;
    halt_it.op = OP_HALT;
    offer_instr(halt_it, 1'b0, '0);
    for (int n = 0; n < HALT_TAIL; n++) offer_instr(random_instr(1'($urandom_range(1))), 1'b0, '0);
    in_valid <= 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_outcomes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
